/* src/fac_pkg.sv */
package fac_pkg;

    // table geometry
    localparam int NUM_FRAMES = 1024;
    localparam int FRAME_W    = 10;
    localparam int THREAD_W   = 8;
    localparam int PAGE_W     = 20;
    localparam int ROW_BITS   = 32;
    localparam int BIT_W      = $clog2(ROW_BITS);
    localparam int NUM_ROWS   = NUM_FRAMES / ROW_BITS;
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int LAST_ROW   = NUM_ROWS - 1;

    localparam logic [FRAME_W-1:0] BASE_RESET = FRAME_W'(256);

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_SWAP  = 2'd1;
    localparam logic [1:0] CMD_REF   = 2'd2;

    // row scan modes
    localparam logic [1:0] MODE_FREE  = 2'd0;
    localparam logic [1:0] MODE_SWEEP = 2'd1;
    localparam logic [1:0] MODE_REF   = 2'd2;

    typedef logic [ROW_BITS-1:0] t_row;

    typedef struct packed {
        t_row valid;
        t_row acc;
    } t_flag_row;

    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic [PAGE_W-1:0]   page;
    } t_meta;

    typedef struct packed {
        logic [1:0] mode;
        t_row       mask;
        t_row       force_oh;
        logic       last_visit;
    } t_scan_req;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pick;
        logic             old_valid;
        t_flag_row        new_row;
    } t_scan_rsp;

    // bits at or above position b
    function automatic t_row ge_mask(input logic [BIT_W-1:0] b);
        ge_mask = {ROW_BITS{1'b1}} << b;
    endfunction

    function automatic t_row bit_oh(input logic [BIT_W-1:0] b);
        bit_oh = t_row'(1) << b;
    endfunction

endpackage

/* src/fac_flag_store.sv */
module fac_flag_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [fac_pkg::ROW_W-1:0] i_rd_row,
    output fac_pkg::t_flag_row       o_rd_data,
    input  logic                     i_wr_en,
    input  logic [fac_pkg::ROW_W-1:0] i_wr_row,
    input  fac_pkg::t_flag_row       i_wr_data
);
    import fac_pkg::*;

    t_flag_row                r_mem [NUM_ROWS];
    logic [NUM_ROWS-1:0]      r_init;
    t_flag_row                r_rd_data;
    logic                     r_rd_init;

    // valid and accessed bits, one row of frames per entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    // per-row written marks, a row never written reads as all clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_init[i_wr_row] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_init <= r_init[i_rd_row];
            end
        end
    end

    assign o_rd_data = r_rd_init ? r_rd_data : '0;

endmodule

/* src/fac_meta_store.sv */
module fac_meta_store (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [fac_pkg::FRAME_W-1:0] i_rd_frame,
    output fac_pkg::t_meta              o_rd_data,
    input  logic                        i_wr_en,
    input  logic [fac_pkg::FRAME_W-1:0] i_wr_frame,
    input  fac_pkg::t_meta              i_wr_data
);
    import fac_pkg::*;

    t_meta r_mem [NUM_FRAMES];
    t_meta r_rd_data;

    // owner thread and page per frame
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_frame] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_frame];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/fac_row_scan.sv */
module fac_row_scan (
    input  fac_pkg::t_flag_row i_row,
    input  fac_pkg::t_scan_req i_req,
    output fac_pkg::t_scan_rsp o_rsp
);
    import fac_pkg::*;

    t_row             cand;
    t_row             first_oh;
    t_row             sel;
    t_row             clr;
    logic [BIT_W-1:0] pick;
    logic             found;

    // candidates: free frames or frames without a second chance
    always_comb begin
        if (i_req.mode == MODE_FREE) begin
            cand = ~i_row.valid & i_req.mask;
        end else begin
            cand = ~i_row.acc & i_req.mask;
        end
        found    = |cand;
        first_oh = cand & ((~cand) + t_row'(1));
    end

    // encode lowest candidate
    always_comb begin
        pick = '0;
        for (int i = 0; i < ROW_BITS; i++) begin
            if (first_oh[i]) begin
                pick = pick | BIT_W'(i);
            end
        end
    end

    // build the row written back
    always_comb begin
        sel = '0;
        clr = '0;
        o_rsp.new_row = i_row;
        case (i_req.mode)
            MODE_FREE: begin
                sel = first_oh;
                o_rsp.new_row.valid = i_row.valid | sel;
                o_rsp.new_row.acc   = i_row.acc & ~sel;
            end
            MODE_SWEEP: begin
                // accessed frames passed over lose their second chance
                if (found) begin
                    clr = i_req.mask & (first_oh - t_row'(1));
                    sel = first_oh;
                end else begin
                    clr = i_req.mask;
                    sel = i_req.last_visit ? i_req.force_oh : '0;
                end
                o_rsp.new_row.valid = i_row.valid | sel;
                o_rsp.new_row.acc   = i_row.acc & ~clr & ~sel;
            end
            MODE_REF: begin
                o_rsp.new_row.acc = i_row.acc | i_req.force_oh;
            end
            default: begin
                o_rsp.new_row = i_row;
            end
        endcase
        o_rsp.found     = found;
        o_rsp.pick      = pick;
        o_rsp.old_valid = |(i_row.valid & sel);
    end

endmodule

/* src/frame_alloc_clock_replacement.sv */
// channel | direction | handshake                  | payload
// cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_first_user_frame
// request | in        | i_valid / o_ready          | i_cmd, i_thread_id, i_page_number, i_frame_ref
// result  | out       | o_valid / i_ready          | o_frame, o_evicted, o_old_thread, o_old_page
//
// one request at a time; flags live in a 32-row RAM of 32 frames each, and every row
// visited is first read from the RAM, then evaluated and written back
// allocate/swap in: the row visits, then owner RAM read, owner RAM write, output, idle;
// worst case an allocate visits 32 + 33 rows, a reference one row, an unused command none
// reset is synchronous; unwritten flag rows read as clear, so no clearing pass is needed
// a held result in the output register stalls only the final step of the next request
module frame_alloc_clock_replacement (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fac_pkg::FRAME_W-1:0]  i_cfg_first_user_frame,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_cmd,
    input  logic [fac_pkg::THREAD_W-1:0] i_thread_id,
    input  logic [fac_pkg::PAGE_W-1:0]   i_page_number,
    input  logic [fac_pkg::FRAME_W-1:0]  i_frame_ref,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fac_pkg::FRAME_W-1:0]  o_frame,
    output logic                         o_evicted,
    output logic [fac_pkg::THREAD_W-1:0] o_old_thread,
    output logic [fac_pkg::PAGE_W-1:0]   o_old_page
);
    import fac_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_EVAL    = 3'd2;
    localparam logic [2:0] S_META_RD = 3'd3;
    localparam logic [2:0] S_META_WB = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]          r_state;
    logic [FRAME_W-1:0]  r_cfg;
    logic [FRAME_W-1:0]  r_hand;
    logic [FRAME_W-1:0]  r_start;
    logic [FRAME_W-1:0]  r_chosen;
    logic [ROW_W-1:0]    r_row;
    logic [1:0]          r_mode;
    logic                r_last_visit;
    logic                r_old_valid;
    logic [THREAD_W-1:0] r_tid;
    logic [PAGE_W-1:0]   r_page;
    logic [FRAME_W-1:0]  r_fref;

    logic [FRAME_W-1:0]  r_res_frame;
    logic                r_res_evicted;
    logic [THREAD_W-1:0] r_res_thread;
    logic [PAGE_W-1:0]   r_res_page;

    logic                r_out_valid;
    logic [FRAME_W-1:0]  r_out_frame;
    logic                r_out_evicted;
    logic [THREAD_W-1:0] r_out_thread;
    logic [PAGE_W-1:0]   r_out_page;

    logic [FRAME_W-1:0]  base;
    logic [ROW_W-1:0]    base_row;
    logic [FRAME_W-1:0]  hand_adj;
    logic [ROW_W-1:0]    next_row;
    logic [ROW_W-1:0]    start_row;
    t_row                region;
    t_scan_req           scan_req;
    t_scan_rsp           scan_rsp;
    t_flag_row           flag_rd;
    t_meta               meta_rd;
    t_meta               meta_wr;
    logic                accept;
    logic                out_load;

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // effective base and hand brought back into the user region
    always_comb begin
        base = r_cfg;
        if (32'(r_cfg) >= NUM_FRAMES) begin
            base = FRAME_W'(NUM_FRAMES - 1);
        end
        hand_adj = r_hand;
        if (r_hand < base || 32'(r_hand) >= NUM_FRAMES) begin
            hand_adj = base;
        end
        base_row  = base[FRAME_W-1:BIT_W];
        start_row = r_start[FRAME_W-1:BIT_W];
        if (r_row == ROW_W'(LAST_ROW)) begin
            next_row = base_row;
        end else begin
            next_row = r_row + ROW_W'(1);
        end
    end

    // scan mask for the current row
    always_comb begin
        if (r_row > base_row) begin
            region = '1;
        end else if (r_row == base_row) begin
            region = ge_mask(base[BIT_W-1:0]);
        end else begin
            region = '0;
        end
        scan_req.mode       = r_mode;
        scan_req.last_visit = r_last_visit;
        scan_req.force_oh   = '0;
        scan_req.mask       = '0;
        case (r_mode)
            MODE_FREE: begin
                scan_req.mask = region;
            end
            MODE_SWEEP: begin
                scan_req.force_oh = bit_oh(r_start[BIT_W-1:0]);
                if (r_last_visit) begin
                    scan_req.mask = region & ~ge_mask(r_start[BIT_W-1:0]);
                end else if (r_row == start_row) begin
                    scan_req.mask = region & ge_mask(r_start[BIT_W-1:0]);
                end else begin
                    scan_req.mask = region;
                end
            end
            MODE_REF: begin
                scan_req.force_oh = bit_oh(r_fref[BIT_W-1:0]);
            end
            default: begin
                scan_req.mask = '0;
            end
        endcase
    end

    fac_flag_store u_flags (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == S_READ),
        .i_rd_row  (r_row),
        .o_rd_data (flag_rd),
        .i_wr_en   (r_state == S_EVAL),
        .i_wr_row  (r_row),
        .i_wr_data (scan_rsp.new_row)
    );

    fac_row_scan u_scan (
        .i_row (flag_rd),
        .i_req (scan_req),
        .o_rsp (scan_rsp)
    );

    assign meta_wr.thread = r_tid;
    assign meta_wr.page   = r_page;

    fac_meta_store u_meta (
        .i_clk      (i_clk),
        .i_rd_en    (r_state == S_META_RD),
        .i_rd_frame (r_chosen),
        .o_rd_data  (meta_rd),
        .i_wr_en    (r_state == S_META_WB),
        .i_wr_frame (r_chosen),
        .i_wr_data  (meta_wr)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= BASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_first_user_frame;
        end
    end

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hand       <= BASE_RESET;
            r_mode       <= MODE_FREE;
            r_last_visit <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tid  <= i_thread_id;
                        r_page <= i_page_number;
                        r_fref <= i_frame_ref;
                        case (i_cmd)
                            CMD_ALLOC: begin
                                r_mode  <= MODE_FREE;
                                r_row   <= base_row;
                                r_state <= S_READ;
                            end
                            CMD_SWAP: begin
                                r_mode       <= MODE_SWEEP;
                                r_hand       <= hand_adj;
                                r_start      <= hand_adj;
                                r_row        <= hand_adj[FRAME_W-1:BIT_W];
                                r_last_visit <= 1'b0;
                                r_state      <= S_READ;
                            end
                            CMD_REF: begin
                                r_mode  <= MODE_REF;
                                r_row   <= i_frame_ref[FRAME_W-1:BIT_W];
                                r_state <= S_READ;
                            end
                            default: begin
                                r_res_frame   <= '0;
                                r_res_evicted <= 1'b0;
                                r_res_thread  <= '0;
                                r_res_page    <= '0;
                                r_state       <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    case (r_mode)
                        MODE_FREE: begin
                            if (scan_rsp.found) begin
                                r_chosen    <= {r_row, scan_rsp.pick};
                                r_old_valid <= 1'b0;
                                r_state     <= S_META_RD;
                            end else if (r_row == ROW_W'(LAST_ROW)) begin
                                // no free user frame, fall back to the clock sweep
                                r_mode       <= MODE_SWEEP;
                                r_hand       <= hand_adj;
                                r_start      <= hand_adj;
                                r_row        <= hand_adj[FRAME_W-1:BIT_W];
                                r_last_visit <= 1'b0;
                                r_state      <= S_READ;
                            end else begin
                                r_row   <= r_row + ROW_W'(1);
                                r_state <= S_READ;
                            end
                        end
                        MODE_SWEEP: begin
                            if (scan_rsp.found) begin
                                r_chosen    <= {r_row, scan_rsp.pick};
                                r_hand      <= {r_row, scan_rsp.pick};
                                r_old_valid <= scan_rsp.old_valid;
                                r_state     <= S_META_RD;
                            end else if (r_last_visit) begin
                                // full wrap, the starting frame is taken
                                r_chosen    <= r_start;
                                r_hand      <= r_start;
                                r_old_valid <= scan_rsp.old_valid;
                                r_state     <= S_META_RD;
                            end else begin
                                r_row        <= next_row;
                                r_last_visit <= (next_row == start_row);
                                r_state      <= S_READ;
                            end
                        end
                        default: begin
                            r_res_frame   <= r_fref;
                            r_res_evicted <= 1'b0;
                            r_res_thread  <= '0;
                            r_res_page    <= '0;
                            r_state       <= S_DONE;
                        end
                    endcase
                end
                S_META_RD: begin
                    r_state <= S_META_WB;
                end
                S_META_WB: begin
                    r_res_frame   <= r_chosen;
                    r_res_evicted <= r_old_valid;
                    r_res_thread  <= r_old_valid ? meta_rd.thread : '0;
                    r_res_page    <= r_old_valid ? meta_rd.page : '0;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_frame   <= r_res_frame;
            r_out_evicted <= r_res_evicted;
            r_out_thread  <= r_res_thread;
            r_out_page    <= r_res_page;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame      = r_out_frame;
    assign o_evicted    = r_out_evicted;
    assign o_old_thread = r_out_thread;
    assign o_old_page   = r_out_page;

    // flag RAM data is used in the cycle after its read
    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_READ))
        else $error("row evaluated without a preceding flag read");

    // a frame handed out never lies below the user base
    a_chosen_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_META_RD) |-> (r_chosen >= base))
        else $error("chosen frame below the user base");

    // the sweep leaves the hand on the frame it took
    a_hand_on_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_META_RD && r_mode == MODE_SWEEP) |-> (r_hand == r_chosen))
        else $error("clock hand not on the evicted frame");

    // a reference never reports an eviction
    a_ref_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_mode == MODE_REF) |-> !r_res_evicted)
        else $error("reference command reported an eviction");

endmodule

/* test/frame_table_pkg.sv */
package frame_table_pkg;

    import fac_pkg::*;

    // command code the block leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one expected grant as it leaves the result port
    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        logic                evicted;
        logic [THREAD_W-1:0] old_thread;
        logic [PAGE_W-1:0]   old_page;
    } t_grant;

    class frame_table_model;

        // shadow of the frame table and the clock hand
        bit                  in_use [NUM_FRAMES];
        bit                  accessed [NUM_FRAMES];
        logic [THREAD_W-1:0] owner_of [NUM_FRAMES];
        logic [PAGE_W-1:0]   page_of [NUM_FRAMES];
        int                  hand;
        int                  base_cfg;
        t_grant              pending_grants [$];
        int                  mismatches;

        function new();
            for (int i = 0; i < NUM_FRAMES; i++) begin
                in_use[i]   = 1'b0;
                accessed[i] = 1'b0;
                owner_of[i] = '0;
                page_of[i]  = '0;
            end
            base_cfg   = int'(BASE_RESET);
            hand       = int'(BASE_RESET);
            mismatches = 0;
        endfunction

        function void set_base(input logic [FRAME_W-1:0] value);
            base_cfg = int'(value);
        endfunction

        function int pending();
            return pending_grants.size();
        endfunction

        // base clamped so one user frame always remains
        function int user_base();
            return (base_cfg >= NUM_FRAMES) ? NUM_FRAMES - 1 : base_cfg;
        endfunction

        // lowest free user frame, -1 when the region is full
        function int lowest_free();
            for (int i = user_base(); i < NUM_FRAMES; i++) begin
                if (!in_use[i]) return i;
            end
            return -1;
        endfunction

        // second-chance sweep: clear and skip accessed frames
        function int sweep_victim();
            int base;
            int start;
            base = user_base();
            if (hand < base || hand >= NUM_FRAMES) hand = base;
            start = hand;
            do begin
                if (!accessed[hand]) return hand;
                accessed[hand] = 1'b0;
                hand++;
                if (hand >= NUM_FRAMES) hand = base;
            end while (hand != start);
            return start;
        endfunction

        // apply one accepted request and queue the grant it causes
        function void note_request(input logic [1:0] cmd, input logic [THREAD_W-1:0] tid,
                                   input logic [PAGE_W-1:0] page,
                                   input logic [FRAME_W-1:0] fref);
            t_grant g;
            int     pick;
            g = '0;
            case (cmd)
                CMD_ALLOC, CMD_SWAP: begin
                    pick = (cmd == CMD_ALLOC) ? lowest_free() : -1;
                    if (pick < 0) pick = sweep_victim();
                    if (in_use[pick]) begin
                        g.evicted    = 1'b1;
                        g.old_thread = owner_of[pick];
                        g.old_page   = page_of[pick];
                    end
                    in_use[pick]   = 1'b1;
                    owner_of[pick] = tid;
                    page_of[pick]  = page;
                    accessed[pick] = 1'b0;
                    g.frame        = FRAME_W'(pick);
                end
                CMD_REF: begin
                    g.frame = fref;
                    if (int'(fref) < NUM_FRAMES) accessed[fref] = 1'b1;
                end
                default: begin
                end
            endcase
            pending_grants.push_back(g);
        endfunction

        task report_mismatch(input string what, input logic [31:0] got,
                             input logic [31:0] want);
            $display("mismatch: %s got %0h want %0h", what, got, want);
            mismatches++;
        endtask

        // compare one result transaction with the oldest grant
        task check_result(input logic [FRAME_W-1:0] frame, input logic evicted,
                          input logic [THREAD_W-1:0] old_thread,
                          input logic [PAGE_W-1:0] old_page);
            t_grant g;
            if (pending_grants.size() == 0) begin
                report_mismatch("result with no request outstanding, frame", 32'(frame), 0);
            end else begin
                g = pending_grants.pop_front();
                if (frame !== g.frame)
                    report_mismatch("frame", 32'(frame), 32'(g.frame));
                if (evicted !== g.evicted)
                    report_mismatch("evicted", 32'(evicted), 32'(g.evicted));
                if (old_thread !== g.old_thread)
                    report_mismatch("old_thread", 32'(old_thread), 32'(g.old_thread));
                if (old_page !== g.old_page)
                    report_mismatch("old_page", 32'(old_page), 32'(g.old_page));
            end
        endtask

        task flush_leftovers();
            if (pending_grants.size() != 0)
                report_mismatch("grants never returned, count", pending_grants.size(), 0);
        endtask

    endclass

endpackage

/* test/frame_alloc_clock_replacement_test.sv */
module frame_alloc_clock_replacement_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fac_pkg::*;
    import frame_table_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_ITEMS   = 70;
    localparam int NUM_PHASES    = 7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [FRAME_W-1:0]  i_cfg_first_user_frame = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [1:0]          i_cmd = CMD_ALLOC;
    logic [THREAD_W-1:0] i_thread_id = '0;
    logic [PAGE_W-1:0]   i_page_number = '0;
    logic [FRAME_W-1:0]  i_frame_ref = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [FRAME_W-1:0]  o_frame;
    logic                o_evicted;
    logic [THREAD_W-1:0] o_old_thread;
    logic [PAGE_W-1:0]   o_old_page;

    frame_table_model grant_model = new();

    bit no_idle     = 1'b0;
    bit hold_output = 1'b0;
    int cur_base    = int'(BASE_RESET);
    int stall_count = 0;

    frame_alloc_clock_replacement uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_first_user_frame (i_cfg_first_user_frame),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_cmd                  (i_cmd),
        .i_thread_id            (i_thread_id),
        .i_page_number          (i_page_number),
        .i_frame_ref            (i_frame_ref),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_frame                (o_frame),
        .o_evicted              (o_evicted),
        .o_old_thread           (o_old_thread),
        .o_old_page             (o_old_page)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // result receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end else begin
                i_ready <= no_idle || ($urandom_range(99) >= 17);
            end
        end
    end

    // check every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            grant_model.check_result(o_frame, o_evicted, o_old_thread, o_old_page);
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_count <= 0;
        end else if (stall_count + 1 >= STALL_LIMIT) begin
            $display("** frame_alloc_clock_replacement: FAILED **");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // offer one request and wait until it is taken
    task automatic send_request(input logic [1:0] cmd, input logic [THREAD_W-1:0] tid,
                                input logic [PAGE_W-1:0] page,
                                input logic [FRAME_W-1:0] fref);
        while (!no_idle && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_thread_id   <= tid;
        i_page_number <= page;
        i_frame_ref   <= fref;
        do @(posedge i_clk); while (!o_ready);
        grant_model.note_request(cmd, tid, page, fref);
    endtask

    // stop offering and wait for every grant to come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (grant_model.pending() != 0) @(posedge i_clk);
    endtask

    // write the base register once the block is idle
    task automatic write_base(input logic [FRAME_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid            <= 1'b1;
        i_cfg_first_user_frame <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        grant_model.set_base(value);
        cur_base = int'(value);
    endtask

    // mostly allocate, swap in and references inside the user region
    task automatic random_request();
        logic [1:0]          cmd;
        logic [FRAME_W-1:0]  fref;
        int                  r;
        r = $urandom_range(99);
        if (r < 40)      cmd = CMD_ALLOC;
        else if (r < 60) cmd = CMD_SWAP;
        else if (r < 95) cmd = CMD_REF;
        else             cmd = CMD_UNUSED;
        if ($urandom_range(9) < 8) fref = FRAME_W'($urandom_range(NUM_FRAMES - 1, cur_base));
        else                       fref = FRAME_W'($urandom);
        send_request(cmd, THREAD_W'($urandom), PAGE_W'($urandom), fref);
    endtask

    initial begin
        int phase_base [NUM_PHASES];

        // reset
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset base, field extremes, every command
        send_request(CMD_ALLOC, 8'h00, 20'h00000, 10'h000);
        send_request(CMD_ALLOC, 8'hFF, 20'hFFFFF, 10'h3FF);
        send_request(CMD_SWAP, 8'h5A, 20'h12345, 10'h155);
        send_request(CMD_REF, 8'hA5, 20'h5A5A5, 10'd0);
        send_request(CMD_REF, 8'h00, 20'h00000, 10'd1023);
        send_request(CMD_REF, 8'h3C, 20'hC3C3C, 10'd256);
        send_request(CMD_SWAP, 8'h81, 20'h80001, 10'h2AA);
        send_request(CMD_UNUSED, 8'hFF, 20'hFFFFF, 10'h3FF);
        send_request(CMD_SWAP, 8'h7E, 20'h7FFFE, 10'h000);

        // single user frame: hand pulled up to the base, full wrap
        write_base(10'd1023);
        send_request(CMD_ALLOC, 8'h11, 20'h00111, 10'd0);
        send_request(CMD_ALLOC, 8'h22, 20'h00222, 10'd0);
        send_request(CMD_REF, 8'h00, 20'h00000, 10'd1023);
        send_request(CMD_SWAP, 8'h33, 20'h00333, 10'd0);

        // base zero: sweep wraps from the top frame to frame zero
        write_base(10'd0);
        send_request(CMD_ALLOC, 8'h44, 20'h00444, 10'd0);
        send_request(CMD_SWAP, 8'h55, 20'h00555, 10'd0);
        send_request(CMD_REF, 8'h00, 20'h00000, 10'd1023);
        send_request(CMD_SWAP, 8'h66, 20'h00666, 10'd0);

        // four user frames: fill, mark all accessed, sweep all the way round
        write_base(10'd1020);
        for (int i = 0; i < 4; i++) send_request(CMD_ALLOC, 8'(i + 1), 20'(i * 7), 10'd0);
        for (int i = 0; i < 4; i++) send_request(CMD_REF, 8'h00, 20'h00000, 10'(1020 + i));
        send_request(CMD_SWAP, 8'h99, 20'h99999, 10'd0);

        // random phases over small and large user regions
        phase_base = '{1008, 1016, 1000, 1023, 960, 600, 0};
        phase_base[4] = $urandom_range(1023, 960);
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_base(10'(phase_base[p]));
            if (p == 1) hold_output = 1'b1;
            no_idle = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) random_request();
        end
        no_idle = 1'b0;

        // wind down and decide
        drain_results();
        repeat (20) @(posedge i_clk);
        grant_model.flush_leftovers();
        if (grant_model.mismatches == 0) begin
            $display("** frame_alloc_clock_replacement: PASSED **");
        end else begin
            $display("** frame_alloc_clock_replacement: FAILED **");
        end
        $finish;
    end

endmodule

/* files.f */
src/fac_pkg.sv
src/fac_flag_store.sv
src/fac_meta_store.sv
src/fac_row_scan.sv
src/frame_alloc_clock_replacement.sv
test/frame_table_pkg.sv
test/frame_alloc_clock_replacement_test.sv
